>>> rtl/pmm_pkg.sv
// shared types and constants of the masked 3x3 mean filter
// no dependencies; imported by every module of the block
package pmm_pkg;

    // default row length limit
    localparam int MAX_COLUMNS_DEF = 4096;
    // neighbours visited around each centre cell
    localparam int NEIGHBOUR_COUNT = 8;

    // field widths
    localparam int ELEV_W    = 24;
    localparam int LABEL_W   = 20;
    localparam int CELLS_W   = 4;
    localparam int COL_CFG_W = 13;
    localparam int ROW_CFG_W = 16;
    localparam int CELL_W    = 1 + LABEL_W + ELEV_W;

    // arithmetic widths: sum of nine elevations, rounded-divide operands
    localparam int SUM_W = 28;
    localparam int NUM_W = 28;
    localparam int DEN_W = 5;

    // register port
    localparam int REG_ADDR_W = 3;
    localparam int REG_DATA_W = 32;
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    // item queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // item operation codes
    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic                      op;
        logic signed [ELEV_W-1:0]  elev;
        logic                      miss;
        logic [LABEL_W-1:0]        label;
    } item_t;

endpackage

>>> rtl/pmm_front.sv
// input side: classifies items and holds them in a short queue
// depends on pmm_pkg
module pmm_front
    import pmm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic signed [ELEV_W-1:0] elevation,
    input  logic                     elevation_missing,
    input  logic [LABEL_W-1:0]       parcel_label,
    output logic                     q_valid,
    output item_t                    q_item,
    input  logic                     q_ready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    item_t              new_item;
    logic               push, pop;

    // classify the incoming item
    always_comb
    begin
        new_item.op    = kind ? OP_FLUSH : OP_CELL;
        new_item.elev  = elevation;
        new_item.miss  = elevation_missing;
        new_item.label = parcel_label;
    end

    assign in_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = slot_reg[rd_idx_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // queue pointers
    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_idx_next = (32'(wr_idx_reg) == QUEUE_DEPTH - 1) ? '0 : wr_idx_reg + 1'b1;
        end
        if (pop)
        begin
            rd_idx_next = (32'(rd_idx_reg) == QUEUE_DEPTH - 1) ? '0 : rd_idx_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_idx_reg] <= new_item;
        end
    end

endmodule

>>> rtl/pmm_div.sv
// restoring divider, one quotient bit per cycle
// depends on pmm_pkg
module pmm_div
    import pmm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [DEN_W:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]  quo_reg, quo_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DEN_W+1:0]  trial;

    // one restoring step
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[NUM_W-1]} - {2'b00, den_reg};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
            step_next = STEP_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DEN_W+1])
            begin
                rem_next = trial[DEN_W:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

>>> rtl/pmm_back.sv
// back end: history memory, window gather sequencer, rounded mean, result register
// depends on pmm_pkg and pmm_div
module pmm_back
    import pmm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               restart,
    input  logic [$clog2(MAX_COLUMNS+1)-1:0]   cols,
    input  logic [ROW_CFG_W-1:0]               rows,
    input  logic                               q_valid,
    input  item_t                              q_item,
    output logic                               q_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [ELEV_W-1:0]           filtered_elevation,
    output logic                               filtered_missing,
    output logic [CELLS_W-1:0]                 cells_used,
    output logic                               frame_last
);

    localparam int CNT_W  = $clog2(MAX_COLUMNS + 1);
    localparam int POS_W  = $clog2(MAX_COLUMNS);
    localparam int PEND_W = $clog2(MAX_COLUMNS + 2);
    localparam int HIST_D = 2 * MAX_COLUMNS + 4;
    localparam int AW     = $clog2(HIST_D);
    localparam int OFF_W  = CNT_W + 1;
    localparam int K_W    = $clog2(NEIGHBOUR_COUNT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_LAST  = 3'd2;
    localparam logic [2:0] S_DIVGO = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [CELL_W-1:0]         hist_mem [HIST_D];
    logic [CELL_W-1:0]         rd_data_reg;

    logic [2:0]                state_reg, state_next;
    logic [K_W-1:0]            k_reg, k_next;
    logic [PEND_W-1:0]         pend_reg, pend_next;
    logic [AW-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]             ctr_ptr_reg, ctr_ptr_next;
    logic [POS_W-1:0]          wr_col_reg, wr_col_next;
    logic [ROW_CFG_W-1:0]      wr_row_reg, wr_row_next;
    logic [POS_W-1:0]          ctr_col_reg, ctr_col_next;
    logic [ROW_CFG_W-1:0]      ctr_row_reg, ctr_row_next;
    logic                      drain_reg, drain_next;
    logic                      rd_live_reg;
    logic [K_W-1:0]            rd_tag_reg;
    logic                      rd_use_reg;

    logic                      ctr_miss_reg;
    logic [LABEL_W-1:0]        ctr_label_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [CELLS_W-1:0]        n_reg;

    logic                      out_valid_reg;
    logic signed [ELEV_W-1:0]  out_elev_reg;
    logic                      out_miss_reg;
    logic [CELLS_W-1:0]        out_cells_reg;
    logic                      out_last_reg;

    logic                      pop, mem_we, issue;
    logic                      nb_up, nb_dn, nb_lf, nb_rt;
    logic                      in_grid, arrived, nb_pos, nb_use;
    logic [OFF_W-1:0]          off_abs;
    logic [AW:0]               addr_sum;
    logic [AW-1:0]             rd_addr;
    logic                      wr_col_end, ctr_col_end;
    logic                      wr_row_end, ctr_row_end;
    logic signed [ELEV_W-1:0]  rd_elev;
    logic                      rd_miss;
    logic [LABEL_W-1:0]        rd_label;
    logic [SUM_W-1:0]          sum_mag;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_start, div_done;
    logic [NUM_W-1:0]          div_quot;
    logic [ELEV_W-1:0]         q_mag;
    logic                      out_load, out_free;

    assign wr_col_end  = (CNT_W'(wr_col_reg) == cols - 1'b1);
    assign ctr_col_end = (CNT_W'(ctr_col_reg) == cols - 1'b1);
    assign wr_row_end  = (wr_row_reg == rows - 1'b1);
    assign ctr_row_end = (ctr_row_reg == rows - 1'b1);

    // neighbour direction for the current gather step
    always_comb
    begin
        nb_up = 1'b0;
        nb_dn = 1'b0;
        nb_lf = 1'b0;
        nb_rt = 1'b0;
        unique case (k_reg)
            K_W'(1): nb_up = 1'b1;
            K_W'(2): begin nb_up = 1'b1; nb_rt = 1'b1; end
            K_W'(3): nb_rt = 1'b1;
            K_W'(4): begin nb_dn = 1'b1; nb_rt = 1'b1; end
            K_W'(5): nb_dn = 1'b1;
            K_W'(6): begin nb_dn = 1'b1; nb_lf = 1'b1; end
            K_W'(7): nb_lf = 1'b1;
            K_W'(8): begin nb_up = 1'b1; nb_lf = 1'b1; end
            default: nb_up = 1'b0;
        endcase
    end

    // neighbour qualification and history address
    always_comb
    begin
        in_grid = !(nb_up && ctr_row_reg == '0) && !(nb_dn && ctr_row_end)
               && !(nb_lf && ctr_col_reg == '0) && !(nb_rt && ctr_col_end);
        if (nb_up || nb_dn)
        begin
            if ((nb_up && nb_lf) || (nb_dn && nb_rt))
            begin
                off_abs = OFF_W'(cols) + 1'b1;
            end
            else if ((nb_up && nb_rt) || (nb_dn && nb_lf))
            begin
                off_abs = OFF_W'(cols) - 1'b1;
            end
            else
            begin
                off_abs = OFF_W'(cols);
            end
        end
        else
        begin
            off_abs = OFF_W'(1);
        end
        nb_pos  = nb_dn || (nb_rt && !nb_up);
        // a later neighbour only counts once it has arrived
        arrived = !nb_pos || (32'(off_abs) <= 32'(pend_reg));
        nb_use  = (k_reg != '0) && in_grid && arrived;

        if (k_reg == '0)
        begin
            addr_sum = (AW+1)'(ctr_ptr_reg);
        end
        else if (nb_pos)
        begin
            addr_sum = (AW+1)'(ctr_ptr_reg) + (AW+1)'(off_abs);
            if (32'(addr_sum) >= HIST_D)
            begin
                addr_sum = addr_sum - (AW+1)'(HIST_D);
            end
        end
        else if ((AW+1)'(ctr_ptr_reg) >= (AW+1)'(off_abs))
        begin
            addr_sum = (AW+1)'(ctr_ptr_reg) - (AW+1)'(off_abs);
        end
        else
        begin
            addr_sum = (AW+1)'(ctr_ptr_reg) + (AW+1)'(HIST_D) - (AW+1)'(off_abs);
        end
        rd_addr = addr_sum[AW-1:0];
    end

    assign q_ready  = (state_reg == S_IDLE);
    assign pop      = q_valid && q_ready;
    assign mem_we   = pop && (q_item.op == OP_CELL);
    assign issue    = (state_reg == S_READ);
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (state_reg == S_OUT) && out_free;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        k_next       = k_reg;
        pend_next    = pend_reg;
        wr_ptr_next  = wr_ptr_reg;
        ctr_ptr_next = ctr_ptr_reg;
        wr_col_next  = wr_col_reg;
        wr_row_next  = wr_row_reg;
        ctr_col_next = ctr_col_reg;
        ctr_row_next = ctr_row_reg;
        drain_next   = drain_reg;
        div_start    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                k_next = '0;
                if (pop && q_item.op == OP_CELL)
                begin
                    wr_ptr_next = (32'(wr_ptr_reg) == HIST_D - 1) ? '0 : wr_ptr_reg + 1'b1;
                    if (wr_col_end)
                    begin
                        wr_col_next = '0;
                        wr_row_next = wr_row_end ? '0 : wr_row_reg + 1'b1;
                    end
                    else
                    begin
                        wr_col_next = wr_col_reg + 1'b1;
                    end
                    drain_next = 1'b0;
                    if (32'(pend_reg) > 32'(cols))
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        pend_next = pend_reg + 1'b1;
                    end
                end
                else if (pop && pend_reg != '0)
                begin
                    // flush drains the oldest pending result
                    pend_next  = pend_reg - 1'b1;
                    drain_next = (pend_reg == PEND_W'(1));
                    if (pend_reg == PEND_W'(1))
                    begin
                        wr_col_next = '0;
                        wr_row_next = '0;
                    end
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                k_next = k_reg + 1'b1;
                if (32'(k_reg) == NEIGHBOUR_COUNT)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                state_next = S_DIVGO;
            end
            S_DIVGO:
            begin
                if (ctr_miss_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    ctr_ptr_next = (32'(ctr_ptr_reg) == HIST_D - 1) ? '0 : ctr_ptr_reg + 1'b1;
                    if (drain_reg)
                    begin
                        ctr_col_next = '0;
                        ctr_row_next = '0;
                    end
                    else if (ctr_col_end)
                    begin
                        ctr_col_next = '0;
                        ctr_row_next = ctr_row_end ? '0 : ctr_row_reg + 1'b1;
                    end
                    else
                    begin
                        ctr_col_next = ctr_col_reg + 1'b1;
                    end
                    drain_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // register write restarts the stream
        if (restart)
        begin
            pend_next    = '0;
            wr_col_next  = '0;
            wr_row_next  = '0;
            ctr_col_next = '0;
            ctr_row_next = '0;
            ctr_ptr_next = wr_ptr_reg;
            drain_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            k_reg       <= '0;
            pend_reg    <= '0;
            wr_ptr_reg  <= '0;
            ctr_ptr_reg <= '0;
            wr_col_reg  <= '0;
            wr_row_reg  <= '0;
            ctr_col_reg <= '0;
            ctr_row_reg <= '0;
            drain_reg   <= 1'b0;
            rd_live_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            k_reg       <= k_next;
            pend_reg    <= pend_next;
            wr_ptr_reg  <= wr_ptr_next;
            ctr_ptr_reg <= ctr_ptr_next;
            wr_col_reg  <= wr_col_next;
            wr_row_reg  <= wr_row_next;
            ctr_col_reg <= ctr_col_next;
            ctr_row_reg <= ctr_row_next;
            drain_reg   <= drain_next;
            rd_live_reg <= issue;
        end
    end

    // history memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[wr_ptr_reg] <= {q_item.miss, q_item.label, q_item.elev};
        end
        if (issue)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
        rd_tag_reg <= k_reg;
        rd_use_reg <= nb_use;
    end

    assign rd_elev  = rd_data_reg[ELEV_W-1:0];
    assign rd_label = rd_data_reg[ELEV_W +: LABEL_W];
    assign rd_miss  = rd_data_reg[CELL_W-1];

    // window accumulation
    always_ff @(posedge clk)
    begin
        if (rd_live_reg)
        begin
            if (rd_tag_reg == '0)
            begin
                ctr_miss_reg  <= rd_miss;
                ctr_label_reg <= rd_label;
                sum_reg       <= SUM_W'(rd_elev);
                n_reg         <= CELLS_W'(1);
            end
            else if (rd_use_reg && !rd_miss && rd_label == ctr_label_reg)
            begin
                sum_reg <= sum_reg + SUM_W'(rd_elev);
                n_reg   <= n_reg + 1'b1;
            end
        end
    end

    // rounded divide: (2|sum| + n) / 2n
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign div_num = {sum_mag[SUM_W-2:0], 1'b0} + NUM_W'(n_reg);
    assign div_den = {n_reg, 1'b0};

    pmm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign q_mag = div_quot[ELEV_W-1:0];

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_miss_reg  <= ctr_miss_reg;
            out_cells_reg <= ctr_miss_reg ? '0 : n_reg;
            out_last_reg  <= ctr_row_end && ctr_col_end;
            if (ctr_miss_reg)
            begin
                out_elev_reg <= '0;
            end
            else
            begin
                out_elev_reg <= sum_reg[SUM_W-1] ? -q_mag : q_mag;
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign filtered_elevation = out_elev_reg;
    assign filtered_missing   = out_miss_reg;
    assign cells_used         = out_cells_reg;
    assign frame_last         = out_last_reg;

`ifndef ASSERT_OFF
    // pending count never runs past one row plus one cell
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pend_reg) <= 32'(cols) + 1)
        else $error("pending count beyond window depth");

    // a held result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result register overwritten while stalled");

    // divider finishes only while the sequencer waits for it
    a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("divider finished out of sequence");

    // between items the centre pointer trails the write pointer by the pending count
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (((wr_ptr_reg >= ctr_ptr_reg) ? (32'(wr_ptr_reg) - 32'(ctr_ptr_reg))
          : (32'(wr_ptr_reg) + HIST_D - 32'(ctr_ptr_reg))) == 32'(pend_reg)))
        else $error("history pointers out of step");
`endif

endmodule

>>> rtl/parcel_masked_mean_3x3_core.sv
// top level of the masked 3x3 mean filter: register port, front queue, back end
// depends on pmm_pkg, pmm_front, pmm_back

// Cells stream in row-major order; each result leaves once the cell column_count+1
// positions later has arrived, and flush items drain the tail. A cell that completes
// no window is only written to the history memory. A cell or flush that produces a
// result makes nine reads through the single read port of the history memory, then
// a 28-step serial rounding divide, skipped when the centre is missing. A two-item
// queue takes new items while the back end works, and a result register lets the
// next item start while a result waits. Writing either register restarts the stream.
module parcel_masked_mean_3x3_core
    import pmm_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [REG_ADDR_W-1:0]    paddr,
    input  logic [REG_DATA_W-1:0]    pwdata,
    output logic [REG_DATA_W-1:0]    prdata,
    output logic                     pready,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     kind,
    input  logic signed [ELEV_W-1:0] elevation,
    input  logic                     elevation_missing,
    input  logic [LABEL_W-1:0]       parcel_label,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [ELEV_W-1:0] filtered_elevation,
    output logic                     filtered_missing,
    output logic [CELLS_W-1:0]       cells_used,
    output logic                     frame_last
);

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic [COL_CFG_W-1:0] col_cfg_reg;
    logic [ROW_CFG_W-1:0] row_cfg_reg;
    logic                 reg_wr;
    logic                 reg_idx;
    logic [CNT_W-1:0]     cols_eff;
    logic [ROW_CFG_W-1:0] rows_eff;
    logic                 q_valid, q_ready;
    item_t                q_item;

    // register port
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign reg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cfg_reg <= COL_CFG_W'(4096);
            row_cfg_reg <= ROW_CFG_W'(1);
        end
        else if (reg_wr)
        begin
            unique case (reg_idx)
                REG_COLUMNS: col_cfg_reg <= pwdata[COL_CFG_W-1:0];
                REG_ROWS:    row_cfg_reg <= pwdata[ROW_CFG_W-1:0];
                default:     col_cfg_reg <= col_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_COLUMNS: prdata = REG_DATA_W'(col_cfg_reg);
            REG_ROWS:    prdata = REG_DATA_W'(row_cfg_reg);
            default:     prdata = '0;
        endcase
    end

    // effective frame size
    always_comb
    begin
        if (col_cfg_reg == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (32'(col_cfg_reg) > MAX_COLUMNS)
        begin
            cols_eff = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            cols_eff = CNT_W'(col_cfg_reg);
        end
        rows_eff = (row_cfg_reg == '0) ? ROW_CFG_W'(1) : row_cfg_reg;
    end

    pmm_front u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .kind              (kind),
        .elevation         (elevation),
        .elevation_missing (elevation_missing),
        .parcel_label      (parcel_label),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_ready           (q_ready)
    );

    pmm_back #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .restart            (reg_wr),
        .cols               (cols_eff),
        .rows               (rows_eff),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_ready            (q_ready),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .filtered_elevation (filtered_elevation),
        .filtered_missing   (filtered_missing),
        .cells_used         (cells_used),
        .frame_last         (frame_last)
    );

endmodule
